>>> rtl/qvu_pkg.sv
package qvu_pkg;

	localparam int Q_W        = 16;
	localparam int GAIN_W     = 16;
	localparam int MOVES      = 4;
	localparam int MOVE_W     = 2;
	localparam int COORD_W    = 3;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam int GRID_X_DEF = 8;
	localparam int GRID_Y_DEF = 8;

	localparam logic [GAIN_W-1:0] STEP_GAIN_RST     = 16'd52429;
	localparam logic [GAIN_W-1:0] DISCOUNT_GAIN_RST = 16'd13107;

	// one memory word holds the four action values of a cell
	typedef logic [MOVES-1:0][Q_W-1:0] row_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEARNING_MODE = 2'd0,
		CFG_STEP_GAIN     = 2'd1,
		CFG_DISCOUNT_GAIN = 2'd2
	} cfg_idx_t;

	typedef enum logic [0:0] {
		MODE_QLEARN = 1'b0,
		MODE_SARSA  = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NQ,
		ST_MUL1,
		ST_TGT,
		ST_MUL2,
		ST_WB
	} state_t;

	typedef struct packed {
		logic ld_nq;
		logic ld_mul1;
		logic ld_tgt;
		logic ld_mul2;
	} dp_ctrl_t;

endpackage

>>> rtl/qvu_mem.sv
module qvu_mem #(
	parameter int ROWS   = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  qvu_pkg::row_t     wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output qvu_pkg::row_t     rdata
);
	import qvu_pkg::*;

	row_t mem [ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/qvu_dp.sv
module qvu_dp (
	input  logic                         clk,
	input  qvu_pkg::dp_ctrl_t            ctrl,
	input  qvu_pkg::row_t                row,
	input  logic                         learning_mode,
	input  logic [qvu_pkg::MOVE_W-1:0]   cur_move,
	input  logic [qvu_pkg::MOVE_W-1:0]   next_move,
	input  logic signed [qvu_pkg::Q_W-1:0] reward_value,
	input  logic [qvu_pkg::GAIN_W-1:0]   step_gain,
	input  logic [qvu_pkg::GAIN_W-1:0]   discount_gain,
	output logic signed [qvu_pkg::Q_W-1:0] updated_value,
	output logic                         clipped,
	output qvu_pkg::row_t                row_upd
);
	import qvu_pkg::*;

	logic signed [Q_W-1:0]   max01, max23, max_all, nq_sel;
	logic signed [Q_W-1:0]   nq_s1;
	logic signed [GAIN_W:0]  disc_ext, step_ext;
	logic signed [32:0]      prod1_s2;
	logic signed [Q_W-1:0]   qc_s2;
	row_t                    row_s2;
	logic signed [16:0]      scaled1;
	logic signed [17:0]      sum1;
	logic signed [Q_W-1:0]   target;
	logic                    tgt_sat;
	logic signed [16:0]      td_s3;
	logic                    clip_s3;
	logic signed [33:0]      prod2_s4;
	logic signed [17:0]      scaled2;
	logic signed [18:0]      sum2;
	logic                    nv_sat;

	// next-cell value: best of four, or the chosen action
	assign max01   = ($signed(row[1]) > $signed(row[0])) ? $signed(row[1]) : $signed(row[0]);
	assign max23   = ($signed(row[3]) > $signed(row[2])) ? $signed(row[3]) : $signed(row[2]);
	assign max_all = (max23 > max01) ? max23 : max01;
	assign nq_sel  = (learning_mode == MODE_SARSA) ? $signed(row[next_move]) : max_all;

	assign disc_ext = $signed({1'b0, discount_gain});
	assign step_ext = $signed({1'b0, step_gain});

	always_ff @(posedge clk) begin
		if (ctrl.ld_nq) begin
			nq_s1 <= nq_sel;
		end
		if (ctrl.ld_mul1) begin
			prod1_s2 <= disc_ext * nq_s1;
			qc_s2    <= $signed(row[cur_move]);
			row_s2   <= row;
		end
	end

	// upper bits of the product give the floor of product / 2^16
	assign scaled1 = prod1_s2[32:16];
	assign sum1    = {{2{reward_value[Q_W-1]}}, reward_value} + {scaled1[16], scaled1};
	assign tgt_sat = (sum1[17:15] != 3'b000) && (sum1[17:15] != 3'b111);
	always_comb begin
		if (!tgt_sat) begin
			target = sum1[Q_W-1:0];
		end else if (sum1[17]) begin
			target = 16'sh8000;
		end else begin
			target = 16'sh7FFF;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_tgt) begin
			td_s3   <= {target[Q_W-1], target} - {qc_s2[Q_W-1], qc_s2};
			clip_s3 <= tgt_sat;
		end
		if (ctrl.ld_mul2) begin
			prod2_s4 <= step_ext * td_s3;
		end
	end

	assign scaled2 = prod2_s4[33:16];
	assign sum2    = {{3{qc_s2[Q_W-1]}}, qc_s2} + {scaled2[17], scaled2};
	assign nv_sat  = (sum2[18:15] != 4'b0000) && (sum2[18:15] != 4'b1111);

	always_comb begin
		if (!nv_sat) begin
			updated_value = sum2[Q_W-1:0];
		end else if (sum2[18]) begin
			updated_value = 16'sh8000;
		end else begin
			updated_value = 16'sh7FFF;
		end
		row_upd           = row_s2;
		row_upd[cur_move] = updated_value;
	end

	assign clipped = clip_s3 | nv_sat;

endmodule

>>> rtl/tabular_q_value_update.sv
// Tabular Q-value update, Q-learning or SARSA target, fixed point Q8.8.
//
// Input stream s_*: one transaction per update (cell, action, next cell,
// next action, reward). Result stream m_*: one transaction per update,
// carrying the new table value and a saturation flag in m_tuser.
// Config channel cfg_*: always ready; write only while no update is in flight.
//
// Each update runs these steps from input transaction to result in the output
// register: the next cell's row is read as the transaction is taken, then read
// the current cell's row, discount multiply, target and difference, step
// multiply, write back. The table is a single-port-read row memory, and the
// two row reads plus the two dependent multiplies run in sequence, so a new
// update is accepted only after the previous one has written back.
//
// After reset the table is swept to zero, one cell row per cycle, covering all
// GRID_X*GRID_Y rows (64 at default size); s_tready stays low meanwhile.
// A waiting result sits in the output register and does not block the next
// input transaction; if it is still not taken when the following update is
// ready to write back, that update holds before write-back until m_tready.
module tabular_q_value_update #(
	parameter int GRID_X = qvu_pkg::GRID_X_DEF,
	parameter int GRID_Y = qvu_pkg::GRID_Y_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cur_x, cur_y, cur_move, next_x, next_y, next_move, reward_value
	input  logic [qvu_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// updated_value
	output logic [qvu_pkg::OUT_DATA_W-1:0]    m_tdata,
	// clipped
	output logic                              m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qvu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qvu_pkg::GAIN_W-1:0]        cfg_data
);
	import qvu_pkg::*;

	localparam int ROWS  = GRID_X * GRID_Y;
	localparam int ROW_W = $clog2(ROWS);

	state_t              state_q, state_d;
	logic [ROW_W-1:0]    clr_q;
	logic                learning_mode_q;
	logic [GAIN_W-1:0]   step_gain_q, discount_gain_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [MOVE_W-1:0]   cur_move_q, next_move_q;
	logic signed [Q_W-1:0] reward_q;
	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                m_tuser_q;

	logic [ROW_W-1:0]    in_cur_row, in_next_row;
	logic                mem_we, mem_re, out_load;
	logic [ROW_W-1:0]    mem_waddr, mem_raddr;
	row_t                mem_wdata, mem_rdata, row_upd;
	dp_ctrl_t            dp_ctrl;
	logic signed [Q_W-1:0] nv;
	logic                nv_clip;

	function automatic logic [ROW_W-1:0] cell_row(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		logic [COORD_W-1:0] cx, cy;
		cx = (int'(x) >= GRID_X) ? COORD_W'(GRID_X - 1) : x;
		cy = (int'(y) >= GRID_Y) ? COORD_W'(GRID_Y - 1) : y;
		return ROW_W'(int'(cx) * GRID_Y + int'(cy));
	endfunction

	assign in_cur_row  = cell_row(s_tdata[2:0], s_tdata[5:3]);
	assign in_next_row = cell_row(s_tdata[10:8], s_tdata[13:11]);

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learning_mode_q <= MODE_QLEARN;
			step_gain_q     <= STEP_GAIN_RST;
			discount_gain_q <= DISCOUNT_GAIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LEARNING_MODE: learning_mode_q <= cfg_data[0];
				CFG_STEP_GAIN:     step_gain_q     <= cfg_data;
				CFG_DISCOUNT_GAIN: discount_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_row_q;
		mem_wdata = row_upd;
		mem_re    = 1'b0;
		mem_raddr = cur_row_q;
		out_load  = 1'b0;
		dp_ctrl   = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == ROW_W'(ROWS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready  = 1'b1;
				mem_re    = s_tvalid;
				mem_raddr = in_next_row;
				if (s_tvalid) begin
					state_d = ST_NQ;
				end
			end
			ST_NQ: begin
				dp_ctrl.ld_nq = 1'b1;
				mem_re        = 1'b1;
				state_d       = ST_MUL1;
			end
			ST_MUL1: begin
				dp_ctrl.ld_mul1 = 1'b1;
				state_d         = ST_TGT;
			end
			ST_TGT: begin
				dp_ctrl.ld_tgt = 1'b1;
				state_d        = ST_MUL2;
			end
			ST_MUL2: begin
				dp_ctrl.ld_mul2 = 1'b1;
				state_d         = ST_WB;
			end
			ST_WB: begin
				if (!m_tvalid_q || m_tready) begin
					mem_we   = 1'b1;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cur_row_q   <= in_cur_row;
			cur_move_q  <= s_tdata[7:6];
			next_move_q <= s_tdata[15:14];
			reward_q    <= $signed(s_tdata[31:16]);
		end
	end

	qvu_mem #(
		.ROWS   (ROWS),
		.ADDR_W (ROW_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	qvu_dp u_dp (
		.clk           (clk),
		.ctrl          (dp_ctrl),
		.row           (mem_rdata),
		.learning_mode (learning_mode_q),
		.cur_move      (cur_move_q),
		.next_move     (next_move_q),
		.reward_value  (reward_q),
		.step_gain     (step_gain_q),
		.discount_gain (discount_gain_q),
		.updated_value (nv),
		.clipped       (nv_clip),
		.row_upd       (row_upd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= nv;
			m_tuser_q <= nv_clip;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_NQ))
		else $error("accepted transaction did not start a table read");

	a_wb_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == ST_WB) |=> m_tvalid)
		else $error("write-back without a result in the output register");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("input accepted during the clearing sweep");

	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_WB))
		else $error("result appeared outside write-back");

endmodule
